// ----- hdl/ppo_pkg.sv -----
// ppo_pkg: shared types, codes and constants of the pixel point operation unit
// no dependencies

package ppo_pkg;

	localparam int PIXEL_BITS = 8;
	localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;
	localparam int PIXEL_MID = 127;
	localparam logic [16:0] Q16_ONE = 17'h10000;
	localparam logic [15:0] W_RED = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE = 16'd7471;
	localparam logic [3:0] ROOT_ORDER = 4'd10;

	localparam logic [2:0] MODE_GREY = 3'd0;
	localparam logic [2:0] MODE_BRIGHT = 3'd1;
	localparam logic [2:0] MODE_CONTRAST = 3'd2;
	localparam logic [2:0] MODE_POWER = 3'd3;
	localparam logic [2:0] MODE_NEGATIVE = 3'd4;

	localparam logic [1:0] SRC_RGB = 2'd0;
	localparam logic [1:0] SRC_GREY = 2'd1;
	localparam logic [1:0] SRC_MONO = 2'd2;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_SOURCE_DEPTH = 2'd1;
	localparam logic [1:0] CFG_ADJUST = 2'd2;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_TRANSFORM = 1'b1;

	typedef struct packed {
		logic [2:0]        mode;
		logic [1:0]        source_depth;
		logic signed [7:0] adjust;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] grey;
		logic       mono;
		logic [7:0] peak;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONTRAST,
		ST_DIV,
		ST_ROOT_START,
		ST_ROOT_POW,
		ST_ROOT_CMP,
		ST_POW,
		ST_EMIT
	} back_state_t;

endpackage

// ----- hdl/pixel_point_operation_unit.sv -----
// pixel_point_operation_unit: greyscale, brightness, contrast, power and negative
// point operations; depends on ppo_pkg, ppo_front, ppo_queue, ppo_back
// power mode: iterative, built on the single shared q16 multiplier and the
//   1-bit-per-cycle divider
// scan beats one per cycle while the queue has room; other beats one per cycle, when
//   the output is not stalled, except power and contrast
// reset: asynchronous active low, clears config to defaults, peak and queue

module pixel_point_operation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // red, green, blue, grey, mono, zero pad
	input  logic [1:0]  s_tuser,   // operation, frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // pixel_out
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	ppo_pkg::cfg_t   cfg_q;
	ppo_pkg::entry_t push_entry;
	ppo_pkg::entry_t head;
	logic push_valid;
	logic push_ready;
	logic head_valid;
	logic head_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= ppo_pkg::MODE_GREY;
			cfg_q.source_depth <= ppo_pkg::SRC_GREY;
			cfg_q.adjust <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppo_pkg::CFG_MODE:         cfg_q.mode <= cfg_wdata[2:0];
				ppo_pkg::CFG_SOURCE_DEPTH: cfg_q.source_depth <= cfg_wdata[1:0];
				ppo_pkg::CFG_ADJUST:       cfg_q.adjust <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	ppo_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.source_depth (cfg_q.source_depth),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_entry   (push_entry)
	);

	ppo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_entry  (push_entry),
		.out_valid (head_valid),
		.out_ready (head_ready),
		.out_entry (head)
	);

	ppo_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head       (head),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ----- hdl/ppo_front.sv -----
// ppo_front: accepts input beats, keeps the running peak from scan beats and
// forwards transform beats with the peak they see; depends on ppo_pkg

module ppo_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [39:0]     s_tdata,  // red, green, blue, grey, mono, zero pad
	input  logic [1:0]      s_tuser,  // operation, frame_start
	input  logic [1:0]      source_depth,
	output logic            push_valid,
	input  logic            push_ready,
	output ppo_pkg::entry_t push_entry
);

	logic [7:0] peak_q;
	logic [7:0] peak_base;
	logic       accept;

	assign s_tready = push_ready;
	assign accept = s_tvalid && s_tready;
	assign push_valid = s_tvalid && (s_tuser[0] == ppo_pkg::OP_TRANSFORM);

	assign push_entry.red = s_tdata[7:0];
	assign push_entry.green = s_tdata[15:8];
	assign push_entry.blue = s_tdata[23:16];
	assign push_entry.grey = s_tdata[31:24];
	assign push_entry.mono = s_tdata[32];
	assign push_entry.peak = peak_q;

	// frame start clears the peak before this beat is compared
	assign peak_base = s_tuser[1] ? 8'd0 : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (accept && (s_tuser[0] == ppo_pkg::OP_SCAN)) begin
			if ((source_depth == ppo_pkg::SRC_GREY) && (s_tdata[31:24] > peak_base)) begin
				peak_q <= s_tdata[31:24];
			end else begin
				peak_q <= peak_base;
			end
		end
	end

endmodule

// ----- hdl/ppo_queue.sv -----
// ppo_queue: two-entry queue between front and back
// depends on ppo_pkg

module ppo_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ppo_pkg::entry_t in_entry,
	output logic            out_valid,
	input  logic            out_ready,
	output ppo_pkg::entry_t out_entry
);

	ppo_pkg::entry_t slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign in_ready = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_entry = slot_q[rptr_q];
	assign do_push = in_valid && in_ready;
	assign do_pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop) rptr_q <= ~rptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= in_entry;
	end

endmodule

// ----- hdl/ppo_back.sv -----
// ppo_back: executes queued transform beats; simple modes in one step, contrast
// in two, power through a shared Q16 multiplier and a radix-2 divider; depends on ppo_pkg

module ppo_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ppo_pkg::cfg_t   cfg,
	input  logic            head_valid,
	output logic            head_ready,
	input  ppo_pkg::entry_t head,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata  // pixel_out
);

	ppo_pkg::back_state_t state_q, state_next;

	logic [16:0]        r_q;
	logic [16:0]        lo_q;
	logic [16:0]        hi_q;
	logic [16:0]        mid_q;
	logic [16:0]        acc_q;
	logic [7:0]         cnt_q;
	logic [23:0]        dvd_q;
	logic [16:0]        dvs_q;
	logic [16:0]        rem_q;
	logic [23:0]        quo_q;
	logic [4:0]         dcnt_q;
	logic               div_inv_q;
	logic signed [16:0] num_q;
	logic [7:0]         res_q;
	logic               out_valid_q;
	logic [7:0]         out_data_q;

	logic        out_free;
	logic        is_grey_src;
	logic        go_contrast;
	logic        go_power;
	logic [7:0]  simple_res;
	logic [23:0] luma;
	logic signed [9:0] bright;
	logic [16:0] mul_b;
	logic [33:0] mul_prod;
	logic [16:0] mul_res;
	logic [17:0] rem_sh;
	logic        qbit;
	logic [16:0] rem_next;
	logic [23:0] quo_final;
	logic [17:0] mid_sum;
	logic [7:0]  exp_n;
	logic [24:0] scale_prod;
	logic [15:0] con_x;
	logic [31:0] con_prod;
	logic signed [13:0] con_q;
	logic [7:0]  con_res;
	logic signed [16:0] con_num;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign is_grey_src = (cfg.source_depth == ppo_pkg::SRC_GREY);
	assign go_contrast = is_grey_src && (cfg.mode == ppo_pkg::MODE_CONTRAST);
	assign go_power = is_grey_src && (cfg.mode == ppo_pkg::MODE_POWER)
		&& (head.peak != 8'd0) && (cfg.adjust != 8'sd0);
	assign head_ready = (state_q == ppo_pkg::ST_IDLE) && out_free;

	// modes finished in one step
	always_comb begin
		luma = 24'(ppo_pkg::W_RED * head.red) + 24'(ppo_pkg::W_GREEN * head.green)
			+ 24'(ppo_pkg::W_BLUE * head.blue);
		bright = $signed({2'b00, head.grey}) + 10'(cfg.adjust);
		simple_res = 8'd0;
		if (cfg.mode == ppo_pkg::MODE_GREY) begin
			unique case (cfg.source_depth)
				ppo_pkg::SRC_RGB:  simple_res = luma[23:16];
				ppo_pkg::SRC_GREY: simple_res = head.grey;
				ppo_pkg::SRC_MONO: simple_res = head.mono ? ppo_pkg::PIXEL_MAX : 8'd0;
				default:           simple_res = 8'd0;
			endcase
		end else if (is_grey_src) begin
			unique case (cfg.mode)
				ppo_pkg::MODE_BRIGHT: begin
					if (bright < 0) simple_res = 8'd0;
					else if (bright > 10'sd255) simple_res = ppo_pkg::PIXEL_MAX;
					else simple_res = bright[7:0];
				end
				ppo_pkg::MODE_POWER: begin
					// zero peak gives black, zero exponent gives white
					simple_res = (head.peak == 8'd0) ? 8'd0 : ppo_pkg::PIXEL_MAX;
				end
				ppo_pkg::MODE_NEGATIVE: simple_res = ppo_pkg::PIXEL_MAX - head.grey;
				default: simple_res = 8'd0;
			endcase
		end
	end

	// contrast second step: floor(num/10) through reciprocal 52429 / 2^19 on a biased value
	always_comb begin
		con_x = 16'(num_q + 17'sd20480);
		con_prod = con_x * 16'd52429;
		con_q = $signed({1'b0, con_prod[31:19]}) - 14'sd2048 + 14'(ppo_pkg::PIXEL_MID);
		if (con_q < 0) con_res = 8'd0;
		else if (con_q > 14'sd255) con_res = ppo_pkg::PIXEL_MAX;
		else con_res = con_q[7:0];
	end

	assign con_num = ($signed({1'b0, head.grey}) - 17'sd127) * 17'(cfg.adjust);

	// shared q16 multiplier
	assign mul_b = (state_q == ppo_pkg::ST_ROOT_POW) ? mid_q : lo_q;
	assign mul_prod = acc_q * mul_b;
	assign mul_res = mul_prod[32:16];

	// one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[23]};
	assign qbit = (rem_sh >= {1'b0, dvs_q});
	assign rem_next = qbit ? 17'(rem_sh - {1'b0, dvs_q}) : rem_sh[16:0];
	assign quo_final = {quo_q[22:0], qbit};

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 18'd1;
	assign exp_n = cfg.adjust[7] ? 8'(-cfg.adjust) : 8'(cfg.adjust);
	assign scale_prod = acc_q * ppo_pkg::PIXEL_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ppo_pkg::ST_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ppo_pkg::ST_IDLE: begin
				if (head_valid && out_free) begin
					if (go_contrast) state_next = ppo_pkg::ST_CONTRAST;
					else if (go_power && (head.grey >= head.peak))
						state_next = ppo_pkg::ST_ROOT_START;
					else if (go_power) state_next = ppo_pkg::ST_DIV;
				end
			end
			ppo_pkg::ST_CONTRAST: state_next = ppo_pkg::ST_EMIT;
			ppo_pkg::ST_DIV: begin
				if (dcnt_q == 5'd23)
					state_next = div_inv_q ? ppo_pkg::ST_EMIT : ppo_pkg::ST_ROOT_START;
			end
			ppo_pkg::ST_ROOT_START: begin
				state_next = (lo_q < hi_q) ? ppo_pkg::ST_ROOT_POW : ppo_pkg::ST_POW;
			end
			ppo_pkg::ST_ROOT_POW: begin
				if (cnt_q == 8'(ppo_pkg::ROOT_ORDER - 4'd1)) state_next = ppo_pkg::ST_ROOT_CMP;
			end
			ppo_pkg::ST_ROOT_CMP: state_next = ppo_pkg::ST_ROOT_START;
			ppo_pkg::ST_POW: begin
				if (cnt_q == exp_n) begin
					if (!cfg.adjust[7] || (acc_q == 17'd0)) state_next = ppo_pkg::ST_EMIT;
					else state_next = ppo_pkg::ST_DIV;
				end
			end
			ppo_pkg::ST_EMIT: begin
				if (out_free) state_next = ppo_pkg::ST_IDLE;
			end
			default: state_next = ppo_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ppo_pkg::ST_IDLE) && head_valid && out_free
			&& !go_contrast && !go_power) begin
			out_valid_q <= 1'b1;
		end else if ((state_q == ppo_pkg::ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ppo_pkg::ST_IDLE: begin
				num_q <= con_num;
				// output beat stays put until it is taken
				if (head_valid && out_free) out_data_q <= simple_res;
				r_q <= ppo_pkg::Q16_ONE;
				lo_q <= '0;
				hi_q <= ppo_pkg::Q16_ONE;
				dvd_q <= {head.grey, 16'd0};
				dvs_q <= {9'd0, head.peak};
				rem_q <= '0;
				dcnt_q <= '0;
				div_inv_q <= 1'b0;
			end
			ppo_pkg::ST_CONTRAST: res_q <= con_res;
			ppo_pkg::ST_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_final;
				dvd_q <= {dvd_q[22:0], 1'b0};
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd23) begin
					r_q <= quo_final[16:0];
					lo_q <= '0;
					hi_q <= ppo_pkg::Q16_ONE;
					res_q <= (quo_final > 24'd255) ? ppo_pkg::PIXEL_MAX : quo_final[7:0];
				end
			end
			ppo_pkg::ST_ROOT_START: begin
				mid_q <= mid_sum[17:1];
				acc_q <= ppo_pkg::Q16_ONE;
				cnt_q <= '0;
			end
			ppo_pkg::ST_ROOT_POW: begin
				acc_q <= mul_res;
				cnt_q <= cnt_q + 8'd1;
			end
			ppo_pkg::ST_ROOT_CMP: begin
				if (acc_q <= r_q) lo_q <= mid_q;
				else hi_q <= mid_q - 17'd1;
			end
			ppo_pkg::ST_POW: begin
				if (cnt_q == exp_n) begin
					// positive exponent scales, negative one divides full scale by it
					if (!cfg.adjust[7]) res_q <= scale_prod[23:16];
					else res_q <= ppo_pkg::PIXEL_MAX;
					dvd_q <= {ppo_pkg::PIXEL_MAX, 16'd0};
					dvs_q <= acc_q;
					rem_q <= '0;
					dcnt_q <= '0;
					div_inv_q <= 1'b1;
				end else begin
					acc_q <= mul_res;
					cnt_q <= cnt_q + 8'd1;
				end
			end
			ppo_pkg::ST_EMIT: begin
				if (out_free) out_data_q <= res_q;
			end
			default: begin
			end
		endcase
	end

endmodule
